@@ rtl/gbod_pkg.sv @@
// Package for the heap block occupancy directory.
// Holds sizes, mode and status codes, beat types and the bit-search helpers.
// Used by the top level and the checker; depends on nothing.
package gbod_pkg;

    localparam int MAX_BLOCKS   = 4096;
    localparam int ADDRESS_BITS = 48;
    localparam int CELL_BITS    = 16;
    localparam int TOTAL_W      = 28;
    localparam int MODE_W       = 3;
    localparam int STATUS_W     = 2;

    localparam int SLOT_W    = $clog2(MAX_BLOCKS);
    localparam int COUNT_W   = SLOT_W + 1;
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NWORDS    = MAX_BLOCKS / WORD_BITS;
    localparam int WORD_W    = $clog2(NWORDS);

    localparam logic [CELL_BITS-1:0] CELL_MAX  = '1;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX = '1;

    // Modes. The last two do nothing but report the totals.
    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND_NF  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIND_EMP = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7    = 3'd7;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [SLOT_W-1:0]       block_index;
        logic [ADDRESS_BITS-1:0] block_base;
        logic [CELL_BITS-1:0]    cell_count;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SLOT_W-1:0]    found_index;
        logic [CELL_BITS-1:0] live_cells;
        logic                 block_is_full;
        logic                 block_is_empty;
        logic [TOTAL_W-1:0]   total_live;
        logic [TOTAL_W-1:0]   total_capacity;
    } out_t;

    // One row of the bitmap memory: 64 slots of each flag.
    typedef struct packed {
        logic [WORD_BITS-1:0] active;
        logic [WORD_BITS-1:0] empty;
        logic [WORD_BITS-1:0] full;
    } bm_word_t;

    // Lowest set bit of a row; zero when the row is empty.
    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    // Mask with the bits below n set.
    function automatic logic [WORD_BITS-1:0] below(input logic [BIT_W-1:0] n);
        return (WORD_BITS'(1) << n) - WORD_BITS'(1);
    endfunction

endpackage

@@ rtl/gbod_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module gbod_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/gc_block_occupancy_directory.sv @@
// Top level of the heap block occupancy directory.
// Depends on gbod_pkg and gbod_ram.
//
// The directory takes one beat at a time. Add, remove, allocate and free are a
// read-modify-write of one slot entry and one bitmap row through the wait,
// modify and done states. Searches walk the bitmap memory one 64-slot row at a
// time, a wait and a check state per row; a hit then reads the found slot's
// counts through the encode, slot-wait and finish states, while a miss ends at
// the check of the last row. Errors and the unused modes go straight to done.
// s_ready returns the cycle after a result is loaded into the output register,
// so the next beat is taken while that result still waits on m_ready; the next
// result then waits until the first is taken.
// No clearing pass is needed after reset; the full flags carry a valid bit per
// row and the other stores are only read below the count of handed-out slots.
module gc_block_occupancy_directory (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  gbod_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output gbod_pkg::out_t m_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WAIT  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_ENC   = 3'd4;
    localparam logic [2:0] S_SWAIT = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam int C = gbod_pkg::CELL_BITS;
    localparam int B = gbod_pkg::BIT_W;

    logic [2:0]                          state_reg;
    gbod_pkg::in_t                       in_reg;
    logic [gbod_pkg::COUNT_W-1:0]        used_reg;
    logic [gbod_pkg::TOTAL_W-1:0]        ltot_reg;
    logic [gbod_pkg::TOTAL_W-1:0]        ctot_reg;
    logic [gbod_pkg::NWORDS-1:0]         rv_reg;
    logic [gbod_pkg::WORD_W-1:0]         word_reg;
    logic [gbod_pkg::SLOT_W-1:0]         slot_reg;
    logic [gbod_pkg::WORD_BITS-1:0]      cand_reg;
    logic                                ebit_reg;
    logic                                fbit_reg;
    gbod_pkg::out_t                      res_reg;
    logic                                m_valid_reg;
    gbod_pkg::out_t                      m_data_reg;

    logic [2*C-1:0]                      slot_rdata;
    logic [2*C-1:0]                      slot_wdata;
    logic [3*gbod_pkg::WORD_BITS-1:0]    bm_rdata;
    gbod_pkg::bm_word_t                  bm_rd;
    gbod_pkg::bm_word_t                  bm_wr;
    logic                                mod_we;

    logic [C-1:0]                        cap_rd;
    logic [C-1:0]                        live_rd;
    logic [gbod_pkg::WORD_BITS-1:0]      full_eff;
    logic [B-1:0]                        bsel;
    logic [C-1:0]                        new_cap;
    logic [C-1:0]                        new_live;
    logic                                nf;
    logic                                ne;
    logic                                na;
    logic [gbod_pkg::TOTAL_W-1:0]        ltot_next;
    logic [gbod_pkg::TOTAL_W-1:0]        ctot_next;
    logic [gbod_pkg::TOTAL_W:0]          csum;
    gbod_pkg::out_t                      mod_res;
    gbod_pkg::out_t                      fin_res;

    logic [gbod_pkg::WORD_BITS-1:0]      umask;
    logic [gbod_pkg::WORD_BITS-1:0]      smask;
    logic [gbod_pkg::WORD_BITS-1:0]      cand;
    logic [gbod_pkg::SLOT_W-1:0]         used_m1;
    logic                                last_word;
    logic [B-1:0]                        fbit;

    logic [gbod_pkg::COUNT_W-1:0]        idx_ext;
    logic                                out_free;

    logic [2:0]                          idle_state_next;
    logic [gbod_pkg::SLOT_W-1:0]         idle_slot_next;
    logic [gbod_pkg::WORD_W-1:0]         idle_word_next;
    gbod_pkg::out_t                      idle_res_next;

    // Slot memory holds capacity and live count of each block.
    gbod_ram #(.WIDTH(2 * C), .DEPTH(gbod_pkg::MAX_BLOCKS)) u_slot_ram (
        .aclk  (aclk),
        .we    (mod_we),
        .waddr (slot_reg),
        .wdata (slot_wdata),
        .raddr (slot_reg),
        .rdata (slot_rdata)
    );

    // Bitmap memory holds the active, empty and full flags, one row per 64 slots.
    gbod_ram #(.WIDTH(3 * gbod_pkg::WORD_BITS), .DEPTH(gbod_pkg::NWORDS)) u_bm_ram (
        .aclk  (aclk),
        .we    (mod_we),
        .waddr (word_reg),
        .wdata (bm_wr),
        .raddr (word_reg),
        .rdata (bm_rdata)
    );

    assign bm_rd    = gbod_pkg::bm_word_t'(bm_rdata);
    assign cap_rd   = slot_rdata[2*C-1:C];
    assign live_rd  = slot_rdata[C-1:0];
    assign full_eff = rv_reg[word_reg] ? bm_rd.full : '0;
    assign bsel     = slot_reg[B-1:0];
    assign mod_we   = (state_reg == S_MOD);
    assign slot_wdata = {new_cap, new_live};

    // Read-modify-write of one slot.
    always_comb begin
        new_cap   = cap_rd;
        new_live  = live_rd;
        nf        = full_eff[bsel];
        ne        = bm_rd.empty[bsel];
        na        = bm_rd.active[bsel];
        ltot_next = ltot_reg;
        ctot_next = ctot_reg;
        csum      = {1'b0, ctot_reg} + (gbod_pkg::TOTAL_W + 1)'(in_reg.cell_count);
        case (in_reg.mode)
            gbod_pkg::MODE_ADD: begin
                new_cap   = in_reg.cell_count;
                new_live  = '0;
                nf        = 1'b0;
                ne        = 1'b0;
                na        = |in_reg.block_base;
                ctot_next = csum[gbod_pkg::TOTAL_W] ? gbod_pkg::TOTAL_MAX
                                                    : csum[gbod_pkg::TOTAL_W-1:0];
            end
            gbod_pkg::MODE_REMOVE: begin
                new_cap   = '0;
                new_live  = '0;
                nf        = 1'b0;
                ne        = 1'b0;
                na        = 1'b0;
                ctot_next = (ctot_reg > gbod_pkg::TOTAL_W'(cap_rd))
                          ? ctot_reg - gbod_pkg::TOTAL_W'(cap_rd) : '0;
                ltot_next = (ltot_reg > gbod_pkg::TOTAL_W'(live_rd))
                          ? ltot_reg - gbod_pkg::TOTAL_W'(live_rd) : '0;
            end
            gbod_pkg::MODE_ALLOC: begin
                if (live_rd != gbod_pkg::CELL_MAX) begin
                    new_live = live_rd + C'(1);
                    if (ltot_reg != gbod_pkg::TOTAL_MAX) begin
                        ltot_next = ltot_reg + gbod_pkg::TOTAL_W'(1);
                    end
                end
                if (new_live >= cap_rd) begin
                    nf = 1'b1;
                    ne = 1'b0;
                end
            end
            gbod_pkg::MODE_FREE: begin
                if (live_rd != '0) begin
                    new_live = live_rd - C'(1);
                end
                if (ltot_reg != '0) begin
                    ltot_next = ltot_reg - gbod_pkg::TOTAL_W'(1);
                end
                nf = 1'b0;
                if (new_live == '0) begin
                    ne = 1'b1;
                end
            end
            default: begin
            end
        endcase

        bm_wr             = bm_rd;
        bm_wr.full        = full_eff;
        bm_wr.full[bsel]   = nf;
        bm_wr.empty[bsel]  = ne;
        bm_wr.active[bsel] = na;

        mod_res                = '0;
        mod_res.status         = gbod_pkg::ST_OK;
        mod_res.total_live     = ltot_next;
        mod_res.total_capacity = ctot_next;
        if (in_reg.mode != gbod_pkg::MODE_REMOVE) begin
            mod_res.found_index    = slot_reg;
            mod_res.live_cells     = new_live;
            mod_res.block_is_full  = nf;
            mod_res.block_is_empty = ne;
        end
    end

    // Candidate bits of the current bitmap row during a search.
    always_comb begin
        used_m1 = gbod_pkg::SLOT_W'(used_reg - gbod_pkg::COUNT_W'(1));
        if ({1'b0, word_reg} < used_reg[gbod_pkg::COUNT_W-1:B]) begin
            umask = '1;
        end else if ({1'b0, word_reg} == used_reg[gbod_pkg::COUNT_W-1:B]) begin
            umask = gbod_pkg::below(used_reg[B-1:0]);
        end else begin
            umask = '0;
        end
        if (word_reg == in_reg.block_index[gbod_pkg::SLOT_W-1:B]) begin
            smask = ~gbod_pkg::below(in_reg.block_index[B-1:0]);
        end else begin
            smask = '1;
        end
        if (in_reg.mode == gbod_pkg::MODE_FIND_NF) begin
            cand = bm_rd.active & ~full_eff & umask;
        end else begin
            cand = bm_rd.active & bm_rd.empty & umask & smask;
        end
        last_word = (word_reg == used_m1[gbod_pkg::SLOT_W-1:B]);
        fbit      = gbod_pkg::first_set(cand_reg);
    end

    // Result of a search that found a slot.
    always_comb begin
        fin_res                = res_reg;
        fin_res.status         = gbod_pkg::ST_OK;
        fin_res.found_index    = slot_reg;
        fin_res.live_cells     = live_rd;
        fin_res.block_is_full  = fbit_reg;
        fin_res.block_is_empty = ebit_reg;
    end

    // Slot, row, first state and early result of a newly accepted beat.
    always_comb begin
        idle_state_next              = S_WAIT;
        idle_slot_next               = s_data.block_index;
        idle_word_next               = s_data.block_index[gbod_pkg::SLOT_W-1:B];
        idle_res_next                = '0;
        idle_res_next.total_live     = ltot_reg;
        idle_res_next.total_capacity = ctot_reg;
        case (s_data.mode)
            gbod_pkg::MODE_ADD: begin
                idle_slot_next = used_reg[gbod_pkg::SLOT_W-1:0];
                idle_word_next = used_reg[gbod_pkg::SLOT_W-1:B];
                if (used_reg[gbod_pkg::COUNT_W-1]) begin
                    idle_res_next.status = gbod_pkg::ST_FULL;
                    idle_state_next      = S_DONE;
                end
            end
            gbod_pkg::MODE_REMOVE, gbod_pkg::MODE_ALLOC,
            gbod_pkg::MODE_FREE: begin
                if (idx_ext >= used_reg) begin
                    idle_res_next.status = gbod_pkg::ST_RANGE;
                    idle_state_next      = S_DONE;
                end
            end
            gbod_pkg::MODE_FIND_NF: begin
                idle_word_next = '0;
                if (used_reg == '0) begin
                    idle_res_next.status = gbod_pkg::ST_NONE;
                    idle_state_next      = S_DONE;
                end
            end
            gbod_pkg::MODE_FIND_EMP: begin
                if (idx_ext >= used_reg) begin
                    idle_res_next.status = gbod_pkg::ST_NONE;
                    idle_state_next      = S_DONE;
                end
            end
            default: begin
                idle_state_next = S_DONE;
            end
        endcase
    end

    assign idx_ext  = {1'b0, s_data.block_index};
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            ltot_reg    <= '0;
            ctot_reg    <= '0;
            rv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        res_reg   <= idle_res_next;
                        slot_reg  <= idle_slot_next;
                        word_reg  <= idle_word_next;
                        state_reg <= idle_state_next;
                    end
                end
                S_WAIT: begin
                    if (in_reg.mode inside {gbod_pkg::MODE_FIND_NF,
                                            gbod_pkg::MODE_FIND_EMP}) begin
                        state_reg <= S_CHK;
                    end else begin
                        state_reg <= S_MOD;
                    end
                end
                S_MOD: begin
                    rv_reg[word_reg] <= 1'b1;
                    ltot_reg         <= ltot_next;
                    ctot_reg         <= ctot_next;
                    res_reg          <= mod_res;
                    if (in_reg.mode == gbod_pkg::MODE_ADD) begin
                        used_reg <= used_reg + gbod_pkg::COUNT_W'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_CHK: begin
                    cand_reg <= cand;
                    if (cand != '0) begin
                        state_reg <= S_ENC;
                    end else if (last_word) begin
                        res_reg.status <= gbod_pkg::ST_NONE;
                        state_reg      <= S_DONE;
                    end else begin
                        word_reg  <= word_reg + gbod_pkg::WORD_W'(1);
                        state_reg <= S_WAIT;
                    end
                end
                S_ENC: begin
                    slot_reg  <= {word_reg, fbit};
                    ebit_reg  <= bm_rd.empty[fbit];
                    fbit_reg  <= full_eff[fbit];
                    state_reg <= S_SWAIT;
                end
                S_SWAIT: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    res_reg   <= fin_res;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/gbod_checker.sv @@
// Port-level checker for the heap block occupancy directory, bound to the top.
// Depends on gbod_pkg and gc_block_occupancy_directory.
module gbod_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input gbod_pkg::out_t m_data,
    input logic           m_valid,
    input logic           m_ready
);

    // A result beat that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // A failed or empty-handed item addresses no block.
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != gbod_pkg::ST_OK |->
        m_data.found_index == '0 && m_data.live_cells == '0 &&
        !m_data.block_is_full && !m_data.block_is_empty)
        else $error("error result carries block state");

    // A block is never full and empty at once.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.block_is_full && m_data.block_is_empty))
        else $error("block reported both full and empty");

    // An accepted beat closes the input side for the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on back-to-back cycles");

endmodule

bind gc_block_occupancy_directory gbod_checker u_gbod_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
